@@ design/adxfd_pkg.sv @@
// Package for the ADX ADPCM frame decoder: shared types, register codes and
// frame layout constants. No dependencies.
package adxfd_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [3:0]  code_t;
    typedef logic [15:0]        scale_t;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BYTES   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;

    // Frame layout: two scale bytes, then sixteen coded bytes
    localparam logic [7:0] HEAD_BYTES = 8'd2;
    localparam logic [7:0] CODED_END  = 8'd18;

    // Operands of one prediction step
    typedef struct packed {
        code_t   code;
        scale_t  scale;
        sample_t h1;
        sample_t h2;
    } pred_in_t;

endpackage

@@ design/adxfd_if.sv @@
// Channel interfaces of the ADX frame decoder: byte stream in, samples out.
// Depends on adxfd_pkg.
interface adxfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface adxfd_sample_if;
    logic               valid;
    logic               ready;
    adxfd_pkg::sample_t sample;
    logic               channel;
    logic [4:0]         sample_index;
    logic               last;

    modport source (output valid, output sample, output channel, output sample_index,
                    output last, input ready);
    modport sink   (input valid, input sample, input channel, input sample_index,
                    input last, output ready);
endinterface

@@ design/adxfd_predictor.sv @@
// One ADPCM prediction step: scaled code plus weighted history, floored and
// saturated to 16 bits. Depends on adxfd_pkg.
module adxfd_predictor
(
    input  adxfd_pkg::pred_in_t operands,
    output adxfd_pkg::sample_t  sample
);

    localparam logic signed [33:0] H1_GAIN = 34'sh7298;
    localparam logic signed [33:0] H2_GAIN = 34'sh3350;
    localparam logic signed [21:0] SAT_MAX = 22'sd32767;
    localparam logic signed [21:0] SAT_MIN = -22'sd32768;

    logic signed [20:0] code_term;
    logic signed [33:0] hist_term;
    logic signed [19:0] hist_q;
    logic signed [21:0] total;

    // floor((code*scale*2^14 + hist) / 2^14) == code*scale + floor(hist / 2^14)
    always_comb
    begin
        code_term = 21'(operands.code) * 21'($signed({1'b0, operands.scale}));
        hist_term = H1_GAIN * 34'(operands.h1) - H2_GAIN * 34'(operands.h2);
        hist_q    = $signed(hist_term[33:14]);
        total     = 22'(code_term) + 22'(hist_q);
        if (total > SAT_MAX)
        begin
            sample = 16'sh7fff;
        end
        else if (total < SAT_MIN)
        begin
            sample = 16'sh8000;
        end
        else
        begin
            sample = total[15:0];
        end
    end

endmodule

@@ design/adx_adpcm_frame_decoder.sv @@
// Top level of the ADX ADPCM frame decoder: frame tracking, per-channel
// history and output register. Depends on adxfd_pkg, adxfd_if, adxfd_predictor.
//
// Usage notes
// - byte_stream: one ADX stream byte per transaction, with restart to clear
//   histories, frame position and channel before that byte is handled.
// - sample_stream: one decoded sample per transaction, tagged with channel,
//   index within the frame and last (low-nibble sample of the byte).
// - cfg_write/cfg_index/cfg_data: frame_bytes (index 0) and channel_count
//   (index 1); write only while idle. Other indexes are ignored.
// - Order: the high-nibble sample of a coded byte is presented before the
//   low-nibble sample; each passes from the work slot to the output register.
// - Throughput: the single shared predictor makes one sample a cycle while
//   the receiver takes them, and chains the second sample of a coded byte on
//   the history left by the first. Scale and skipped bytes bypass the predictor.
// - A held output register parts the two sides: the next byte is taken while
//   the low-nibble sample of the previous one still waits.
// - Receiver stall: the output register holds, the predictor stops, and
//   byte_stream.ready drops once the work slot cannot drain.
// - Reset: frame_bytes 18, channel_count 1, histories zero, frame position 0,
//   channel 0. No clearing pass.
module adx_adpcm_frame_decoder
#(
    parameter int MAX_CHANNELS = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    adxfd_byte_if.sink                          byte_stream,
    adxfd_sample_if.source                      sample_stream,
    input  logic                                cfg_write,
    input  logic [adxfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [adxfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = (CH_W + 1 > 2) ? CH_W + 1 : 2;

    // Configuration
    logic [7:0] frame_bytes_reg;
    logic [1:0] channel_count_reg;

    // Frame tracking
    logic [7:0]            pos_reg;
    logic [CH_W-1:0]       chan_reg;
    adxfd_pkg::scale_t     scale_reg;

    // Per-channel history
    adxfd_pkg::sample_t    h1_reg [MAX_CHANNELS];
    adxfd_pkg::sample_t    h2_reg [MAX_CHANNELS];

    // Work slot: one coded byte awaiting its two samples
    logic                  w_valid_reg;
    logic                  w_phase_reg;
    logic [7:0]            w_byte_reg;
    logic [CH_W-1:0]       w_chan_reg;
    logic [3:0]            w_base_reg;
    adxfd_pkg::scale_t     w_scale_reg;

    // Output register
    logic                  o_valid_reg;
    adxfd_pkg::sample_t    o_sample_reg;
    logic                  o_channel_reg;
    logic [4:0]            o_index_reg;
    logic                  o_last_reg;

    logic                  accept;
    logic                  step;
    logic                  w_done;
    logic                  load;
    logic [7:0]            pos_eff;
    logic [CH_W-1:0]       chan_eff;
    logic [7:0]            pos_m2;
    logic [7:0]            flen;
    logic [CNT_W-1:0]      nch;
    logic                  coded;
    logic                  frame_end;
    logic                  chan_wrap;
    logic [7:0]            pos_next;
    logic [CH_W-1:0]       chan_next;
    adxfd_pkg::pred_in_t   operands;
    adxfd_pkg::sample_t    pred_sample;

    // Handshake and slot control
    assign step   = w_valid_reg && (!o_valid_reg || sample_stream.ready);
    assign w_done = step && w_phase_reg;
    assign byte_stream.ready = !w_valid_reg || w_done;
    assign accept = byte_stream.valid && byte_stream.ready;

    // Frame position and channel as seen by the incoming byte
    always_comb
    begin
        pos_eff  = byte_stream.restart ? 8'd0 : pos_reg;
        chan_eff = byte_stream.restart ? '0 : chan_reg;
        pos_m2   = pos_eff - adxfd_pkg::HEAD_BYTES;
        flen     = (frame_bytes_reg < adxfd_pkg::CODED_END) ? adxfd_pkg::CODED_END
                                                             : frame_bytes_reg;
        // channel count 0 acts as 1, above the maximum acts as the maximum
        if (channel_count_reg == 2'd0)
        begin
            nch = CNT_W'(1);
        end
        else if (CNT_W'(channel_count_reg) > CNT_W'(MAX_CHANNELS))
        begin
            nch = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            nch = CNT_W'(channel_count_reg);
        end
        coded     = (pos_eff >= adxfd_pkg::HEAD_BYTES) && (pos_eff < adxfd_pkg::CODED_END);
        frame_end = ({1'b0, pos_eff} + 9'd1) >= {1'b0, flen};
        chan_wrap = (CNT_W'(chan_eff) + CNT_W'(1)) >= nch;
        if (frame_end)
        begin
            pos_next  = 8'd0;
            chan_next = chan_wrap ? '0 : chan_eff + CH_W'(1);
        end
        else
        begin
            pos_next  = pos_eff + 8'd1;
            chan_next = chan_eff;
        end
    end

    assign load = accept && coded;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bytes_reg   <= 8'd18;
            channel_count_reg <= 2'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                adxfd_pkg::CFG_FRAME_BYTES:   frame_bytes_reg   <= cfg_data;
                adxfd_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[1:0];
                default:                      ;
            endcase
        end
    end

    // Frame tracking and scale capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 8'd0;
            chan_reg  <= '0;
            scale_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            chan_reg <= chan_next;
            if (pos_eff == 8'd0)
            begin
                scale_reg <= {byte_stream.data_byte, 8'h00};
            end
            else if (pos_eff == 8'd1)
            begin
                scale_reg[7:0] <= byte_stream.data_byte;
            end
        end
    end

    // Work slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            w_phase_reg <= 1'b0;
        end
        else if (load)
        begin
            w_valid_reg <= 1'b1;
            w_phase_reg <= 1'b0;
        end
        else if (step)
        begin
            w_valid_reg <= !w_phase_reg;
            w_phase_reg <= !w_phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            w_byte_reg  <= byte_stream.data_byte;
            w_chan_reg  <= chan_eff;
            w_base_reg  <= pos_m2[3:0];
            w_scale_reg <= scale_reg;
        end
    end

    // Predictor: high nibble first, then low nibble
    always_comb
    begin
        operands.code  = w_phase_reg ? $signed(w_byte_reg[3:0]) : $signed(w_byte_reg[7:4]);
        operands.scale = w_scale_reg;
        operands.h1    = h1_reg[w_chan_reg];
        operands.h2    = h2_reg[w_chan_reg];
    end

    adxfd_predictor u_predictor
    (
        .operands (operands),
        .sample   (pred_sample)
    );

    // History: restart clears every channel and wins over the last write
    // of the byte before it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                h1_reg[i] <= '0;
                h2_reg[i] <= '0;
            end
        end
        else if (accept && byte_stream.restart)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                h1_reg[i] <= '0;
                h2_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            h1_reg[w_chan_reg] <= pred_sample;
            h2_reg[w_chan_reg] <= h1_reg[w_chan_reg];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (sample_stream.ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            o_sample_reg  <= pred_sample;
            o_channel_reg <= w_chan_reg[0];
            o_index_reg   <= {w_base_reg, w_phase_reg};
            o_last_reg    <= w_phase_reg;
        end
    end

    assign sample_stream.valid        = o_valid_reg;
    assign sample_stream.sample       = o_sample_reg;
    assign sample_stream.channel      = o_channel_reg;
    assign sample_stream.sample_index = o_index_reg;
    assign sample_stream.last         = o_last_reg;

`ifndef SYNTHESIS
    // A waiting high-nibble sample always has its low-nibble partner in the slot
    a_low_pending: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !o_last_reg |-> w_valid_reg && w_phase_reg)
        else $error("high-nibble sample waiting without its partner in the slot");

    // A fresh byte in the slot never sits behind an unfinished pair
    a_fresh_slot: assert property (@(posedge clk) disable iff (!rst_n)
        w_valid_reg && !w_phase_reg |-> !o_valid_reg || o_last_reg)
        else $error("new byte started while a pair was still incomplete");

    // Restart leaves channel 0 history clear
    a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_stream.restart |=> h1_reg[0] == '0 && h2_reg[0] == '0)
        else $error("history not cleared by restart");

    // Restart byte is a scale byte and never loads the slot
    a_restart_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_stream.restart |-> !load)
        else $error("restart byte loaded the work slot");
`endif

endmodule
